// File: src/sbp_pkg.sv
// package for the frame parser with crc-16 check
// holds the parser phase type, result kinds, register indexes and the crc byte update
// no dependencies
`default_nettype none

package sbp_pkg;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_SENDER = 3'd2,
        PH_LEN    = 3'd3,
        PH_MSG    = 3'd4,
        PH_CRC    = 3'd5
    } phase_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // register index is the word address bit above the byte offset
    localparam logic REG_PREAMBLE = 1'b0;
    localparam logic REG_SEED     = 1'b1;

    localparam logic [7:0]  PREAMBLE_RESET = 8'h55;
    localparam logic [15:0] SEED_RESET     = 16'h0000;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    // crc-16 ccitt, msb first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/sbp_frame_parser_crc.sv
// frame parser with crc-16 check: input byte register, parser state machine, result register
// depends on sbp_pkg for the phase type, crc update and register indexes
//
//  channel  | direction | payload                                          | handshake
//  s_       | in        | rx_byte                                          | s_valid / s_ready
//  m_       | out       | kind, payload_byte, byte_index, frame_type,      | m_valid / m_ready
//           |           | source_id, msg_len, crc_ok, error_count          |
//  apb      | in/out    | preamble_value (0x0), crc_seed (0x4)             | psel / penable
//
// one item per cycle while the result register is not stalled: an item goes into the input
// register, the parser and the byte-wide crc update run between it and the result register,
// and the result register loads from them once it is free; m_valid rises only on emitted items
// reset (aresetn low, synchronous) empties both registers and returns to preamble hunt
// a stalled result register holds the input register; s_ready drops only when both are full
`default_nettype none

module sbp_frame_parser_crc
    import sbp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_payload_byte,
    output logic [7:0]       m_byte_index,
    output logic [15:0]      m_frame_type,
    output logic [15:0]      m_source_id,
    output logic [7:0]       m_msg_len,
    output logic             m_crc_ok,
    output logic [31:0]      m_error_count,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [7:0]  preamble_reg;
    logic [15:0] seed_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] sender_reg, sender_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [31:0] fail_count_reg, fail_count_next;

    // result register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_index_reg;
    logic [15:0] out_type_reg;
    logic [15:0] out_sender_reg;
    logic [7:0]  out_len_reg;
    logic        out_ok_reg;
    logic [31:0] out_errors_reg;

    logic        out_free;
    logic        advance;
    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_byte;
    logic [7:0]  emit_index;
    logic        emit_ok;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic        last_payload;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign crc_upd      = crc_byte(crc_reg, in_byte_reg);
    assign rx_crc       = {in_byte_reg, crc_low_reg};
    assign last_payload = ({1'b0, count_reg} + 9'd1) >= {1'b0, len_reg};

    // apb port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= PREAMBLE_RESET;
            seed_reg     <= SEED_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_PREAMBLE: preamble_reg <= pwdata[7:0];
                REG_SEED:     seed_reg     <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PREAMBLE: prdata = {24'd0, preamble_reg};
            REG_SEED:     prdata = {16'd0, seed_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // parser state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            count_reg      <= 8'd0;
            type_reg       <= 16'd0;
            sender_reg     <= 16'd0;
            len_reg        <= 8'd0;
            crc_reg        <= 16'd0;
            crc_low_reg    <= 8'd0;
            fail_count_reg <= 32'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            type_reg       <= type_next;
            sender_reg     <= sender_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            crc_low_reg    <= crc_low_next;
            fail_count_reg <= fail_count_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        type_next       = type_reg;
        sender_next     = sender_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        crc_low_next    = crc_low_reg;
        fail_count_next = fail_count_reg;
        emit            = 1'b0;
        emit_kind       = KIND_PAYLOAD;
        emit_byte       = 8'd0;
        emit_index      = 8'd0;
        emit_ok         = 1'b0;

        unique case (phase_reg)
            PH_WAIT: begin
                if (in_byte_reg == preamble_reg) begin
                    count_next = 8'd0;
                    crc_next   = seed_reg;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                crc_next = crc_upd;
                if (count_reg == 8'd0) begin
                    type_next  = {type_reg[15:8], in_byte_reg};
                    count_next = 8'd1;
                end else begin
                    type_next  = {in_byte_reg, type_reg[7:0]};
                    count_next = 8'd0;
                    phase_next = PH_SENDER;
                end
            end
            PH_SENDER: begin
                crc_next = crc_upd;
                if (count_reg == 8'd0) begin
                    sender_next = {sender_reg[15:8], in_byte_reg};
                    count_next  = 8'd1;
                end else begin
                    sender_next = {in_byte_reg, sender_reg[7:0]};
                    count_next  = 8'd0;
                    phase_next  = PH_LEN;
                end
            end
            PH_LEN: begin
                crc_next   = crc_upd;
                len_next   = in_byte_reg;
                count_next = 8'd0;
                // empty payload goes straight to the crc bytes
                phase_next = (in_byte_reg == 8'd0) ? PH_CRC : PH_MSG;
            end
            PH_MSG: begin
                crc_next   = crc_upd;
                emit       = 1'b1;
                emit_kind  = KIND_PAYLOAD;
                emit_byte  = in_byte_reg;
                emit_index = count_reg;
                if (last_payload) begin
                    count_next = 8'd0;
                    phase_next = PH_CRC;
                end else begin
                    count_next = count_reg + 8'd1;
                end
            end
            PH_CRC: begin
                if (count_reg == 8'd0) begin
                    crc_low_next = in_byte_reg;
                    count_next   = 8'd1;
                end else begin
                    count_next = 8'd0;
                    phase_next = PH_WAIT;
                    emit       = 1'b1;
                    emit_kind  = KIND_END;
                    emit_ok    = (rx_crc == crc_reg);
                    if (rx_crc != crc_reg) begin
                        fail_count_next = fail_count_reg + 32'd1;
                    end
                end
            end
            default: begin
                phase_next = PH_WAIT;
                count_next = 8'd0;
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_kind_reg   <= emit_kind;
            out_byte_reg   <= emit_byte;
            out_index_reg  <= emit_index;
            out_type_reg   <= type_next;
            out_sender_reg <= sender_next;
            out_len_reg    <= len_next;
            out_ok_reg     <= emit_ok;
            out_errors_reg <= fail_count_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_payload_byte = out_byte_reg;
    assign m_byte_index   = out_index_reg;
    assign m_frame_type   = out_type_reg;
    assign m_source_id    = out_sender_reg;
    assign m_msg_len      = out_len_reg;
    assign m_crc_ok       = out_ok_reg;
    assign m_error_count  = out_errors_reg;

`ifndef SYNTHESIS
    // a payload item always lies inside the frame length
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_PAYLOAD) |-> (out_index_reg < out_len_reg))
        else $error("payload index not below frame length");

    // hunting for the preamble starts with a cleared byte count
    a_wait_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WAIT) |-> (count_reg == 8'd0))
        else $error("byte count not clear while hunting");

    // the failure count only ever steps by one, on a failed frame end
    a_fail_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && fail_count_reg != $past(fail_count_reg))
            |-> (fail_count_reg == $past(fail_count_reg) + 32'd1
                 && $past(phase_reg) == PH_CRC && $past(advance)))
        else $error("failure count changed outside a failed frame end");
`endif

endmodule

`default_nettype wire
